// ----- design/nsc_pkg.sv -----
// Shared types, character constants and helpers for the NMEA sentence classifier.
package nsc_pkg;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;

    localparam logic [2:0] POS_SAT   = 3'd6;
    localparam logic [2:0] POS_HDR_LO = 3'd1;
    localparam logic [2:0] POS_HDR_HI = 3'd5;
    localparam logic [1:0] HEX_MAX   = 2'd2;

    localparam logic [39:0] TAG_PFLAU = 40'("PFLAU");
    localparam logic [39:0] TAG_PFLAA = 40'("PFLAA");
    localparam logic [39:0] TAG_PFLAV = 40'("PFLAV");
    localparam logic [39:0] TAG_PFLAE = 40'("PFLAE");
    localparam logic [39:0] TAG_PFLAQ = 40'("PFLAQ");
    localparam logic [23:0] TAG_RMC   = 24'("RMC");
    localparam logic [23:0] TAG_GGA   = 24'("GGA");
    localparam logic [23:0] TAG_RMZ   = 24'("RMZ");

    typedef enum logic [3:0] {
        TYPE_UNKNOWN = 4'd0,
        TYPE_PFLAU   = 4'd1,
        TYPE_PFLAA   = 4'd2,
        TYPE_RMC     = 4'd3,
        TYPE_GGA     = 4'd4,
        TYPE_RMZ     = 4'd5,
        TYPE_PFLAV   = 4'd6,
        TYPE_PFLAE   = 4'd7,
        TYPE_PFLAQ   = 4'd8
    } sentence_type_t;

    // header positions 1..5, position 1 in the most significant byte
    typedef logic [0:4][7:0] header_t;

    typedef struct packed {
        sentence_type_t stype;
        logic           ok;
        logic [7:0]     csum;
        logic [7:0]     rsum;
        logic           present;
    } result_t;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ----- design/nsc_classify.sv -----
// Sentence type lookup from the five header bytes.
module nsc_classify (
    input  nsc_pkg::header_t        header,
    output nsc_pkg::sentence_type_t stype
);

    always_comb
    begin
        priority if (header == nsc_pkg::TAG_PFLAU)
        begin
            stype = nsc_pkg::TYPE_PFLAU;
        end
        else if (header == nsc_pkg::TAG_PFLAA)
        begin
            stype = nsc_pkg::TYPE_PFLAA;
        end
        else if (header[2:4] == nsc_pkg::TAG_RMC)
        begin
            stype = nsc_pkg::TYPE_RMC;
        end
        else if (header[2:4] == nsc_pkg::TAG_GGA)
        begin
            stype = nsc_pkg::TYPE_GGA;
        end
        else if (header[2:4] == nsc_pkg::TAG_RMZ)
        begin
            stype = nsc_pkg::TYPE_RMZ;
        end
        else if (header == nsc_pkg::TAG_PFLAV)
        begin
            stype = nsc_pkg::TYPE_PFLAV;
        end
        else if (header == nsc_pkg::TAG_PFLAE)
        begin
            stype = nsc_pkg::TYPE_PFLAE;
        end
        else if (header == nsc_pkg::TAG_PFLAQ)
        begin
            stype = nsc_pkg::TYPE_PFLAQ;
        end
        else
        begin
            stype = nsc_pkg::TYPE_UNKNOWN;
        end
    end

endmodule

// ----- design/nsc_parser.sv -----
// Per-sentence state: header capture, running XOR and checksum digit parsing.
module nsc_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       data_byte,
    input  logic             end_of_sentence,
    output nsc_pkg::result_t result
);

    logic [2:0]       pos_reg, pos_next;
    nsc_pkg::header_t hdr_reg, hdr_next;
    logic [7:0]       xor_reg, xor_next;
    logic             star_reg, star_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             stop_reg, stop_next;
    logic [7:0]       rval_reg, rval_next;
    logic [4:0]       hex;
    logic [2:0]       hdr_idx;
    nsc_pkg::sentence_type_t stype;

    always_comb
    begin
        pos_next  = pos_reg;
        hdr_next  = hdr_reg;
        xor_next  = xor_reg;
        star_next = star_reg;
        cnt_next  = cnt_reg;
        stop_next = stop_reg;
        rval_next = rval_reg;
        hex       = nsc_pkg::hex_decode(data_byte);
        hdr_idx   = pos_reg - 3'd1;

        if (pos_reg >= nsc_pkg::POS_HDR_LO && pos_reg <= nsc_pkg::POS_HDR_HI)
        begin
            hdr_next[hdr_idx] = data_byte;
        end
        if (pos_reg < nsc_pkg::POS_SAT)
        begin
            pos_next = pos_reg + 3'd1;
        end

        if (!star_reg)
        begin
            if (data_byte == nsc_pkg::CH_STAR)
            begin
                star_next = 1'b1;
            end
            else if (data_byte != nsc_pkg::CH_DOLLAR && data_byte != nsc_pkg::CH_BANG)
            begin
                xor_next = xor_reg ^ data_byte;
            end
        end
        else if (!stop_reg && cnt_reg < nsc_pkg::HEX_MAX)
        begin
            if (!hex[4])
            begin
                stop_next = 1'b1;
            end
            else
            begin
                rval_next = {rval_reg[3:0], hex[3:0]};
                cnt_next  = cnt_reg + 2'd1;
            end
        end
    end

    nsc_classify u_classify (
        .header (hdr_next),
        .stype  (stype)
    );

    always_comb
    begin
        result.stype   = stype;
        result.present = (cnt_next != 2'd0);
        result.csum    = xor_next;
        result.rsum    = result.present ? rval_next : 8'd0;
        result.ok      = result.present && (rval_next == xor_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hdr_reg  <= '0;
            xor_reg  <= '0;
            star_reg <= 1'b0;
            cnt_reg  <= '0;
            stop_reg <= 1'b0;
            rval_reg <= '0;
        end
        else if (fire)
        begin
            if (end_of_sentence)
            begin
                pos_reg  <= '0;
                hdr_reg  <= '0;
                xor_reg  <= '0;
                star_reg <= 1'b0;
                cnt_reg  <= '0;
                stop_reg <= 1'b0;
                rval_reg <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                hdr_reg  <= hdr_next;
                xor_reg  <= xor_next;
                star_reg <= star_next;
                cnt_reg  <= cnt_next;
                stop_reg <= stop_next;
                rval_reg <= rval_next;
            end
        end
    end

endmodule

// ----- design/nmea_sentence_classify_check.sv -----
// Top level of the NMEA sentence classifier and checksum checker.
// One byte per cycle while no last byte waits for the output: a transfer lands in the
// input register and is folded into the sentence state the next cycle; the flagged last
// byte writes one result into the output register, which drives out_valid. Non-final
// bytes advance even while a result waits; only a last byte waits for the output slot.
// The sentence state clears itself after each result.
module nmea_sentence_classify_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_sentence,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] sentence_type,
    output logic       checksum_ok,
    output logic [7:0] computed_sum,
    output logic [7:0] received_sum,
    output logic       sum_present
);

    logic             s1_valid_reg;
    logic [7:0]       s1_data_reg;
    logic             s1_eos_reg;
    logic             out_valid_reg;
    nsc_pkg::result_t out_reg;
    nsc_pkg::result_t result;
    logic             out_free;
    logic             fire;
    logic             in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && (!s1_eos_reg || out_free);
    assign in_stall = s1_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    nsc_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .data_byte       (s1_data_reg),
        .end_of_sentence (s1_eos_reg),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= data_byte;
            s1_eos_reg  <= end_of_sentence;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && s1_eos_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && s1_eos_reg)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sentence_type = out_reg.stype;
    assign checksum_ok   = out_reg.ok;
    assign computed_sum  = out_reg.csum;
    assign received_sum  = out_reg.rsum;
    assign sum_present   = out_reg.present;

`ifndef SYNTHESIS
    a_ok_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && checksum_ok |-> sum_present && computed_sum == received_sum)
        else $error("checksum_ok without matching sum");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sum_present |-> received_sum == 8'd0 && !checksum_ok)
        else $error("missing checksum reported nonzero");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_eos_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_eos_reg |=> out_valid)
        else $error("last byte produced no result");
`endif

endmodule

// ----- tb/tb_nmea_sentence_classify_check.sv -----
// Self-checking testbench for the NMEA sentence classifier and checksum checker.
`timescale 1ns / 100ps

module tb_nmea_sentence_classify_check;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } nmea_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'd0;
    logic       end_of_sentence = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] sentence_type;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       sum_present;

    nmea_byte_t         byte_queue[$];
    nmea_byte_t         next_byte;
    nsc_pkg::result_t   sentence_results[$];
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         mismatch_count = 0;
    int         pushed_count = 0;

    // sentence state of the predictor
    logic [2:0]       pos_count = 3'd0;
    nsc_pkg::header_t hdr = '0;
    logic [7:0] run_xor = 8'd0;
    logic       star_hit = 1'b0;
    logic [1:0] digit_cnt = 2'd0;
    logic       digits_done = 1'b0;
    logic [7:0] digit_val = 8'd0;

    logic [7:0] pfla_last[5] = '{"U", "A", "V", "E", "Q"};
    logic [23:0] tri_tags[3] = '{nsc_pkg::TAG_RMC, nsc_pkg::TAG_GGA, nsc_pkg::TAG_RMZ};
    int phase_send[5] = '{0, 87, 0, 27, 0};
    int phase_stall[5] = '{0, 0, 87, 27, 0};

    nmea_sentence_classify_check i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .end_of_sentence (end_of_sentence),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sentence_type   (sentence_type),
        .checksum_ok     (checksum_ok),
        .computed_sum    (computed_sum),
        .received_sum    (received_sum),
        .sum_present     (sum_present)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10)
        begin
            return 8'("0") + 8'(v);
        end
        return (lower ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
    endfunction

    function automatic nsc_pkg::sentence_type_t classify_header(input nsc_pkg::header_t h);
        if (h == nsc_pkg::TAG_PFLAU) return nsc_pkg::TYPE_PFLAU;
        if (h == nsc_pkg::TAG_PFLAA) return nsc_pkg::TYPE_PFLAA;
        if (h[2:4] == nsc_pkg::TAG_RMC) return nsc_pkg::TYPE_RMC;
        if (h[2:4] == nsc_pkg::TAG_GGA) return nsc_pkg::TYPE_GGA;
        if (h[2:4] == nsc_pkg::TAG_RMZ) return nsc_pkg::TYPE_RMZ;
        if (h == nsc_pkg::TAG_PFLAV) return nsc_pkg::TYPE_PFLAV;
        if (h == nsc_pkg::TAG_PFLAE) return nsc_pkg::TYPE_PFLAE;
        if (h == nsc_pkg::TAG_PFLAQ) return nsc_pkg::TYPE_PFLAQ;
        return nsc_pkg::TYPE_UNKNOWN;
    endfunction

    // fold one accepted byte into the sentence state; the last byte yields a result
    task automatic fold_byte(input logic [7:0] c, input logic last);
        int               nib;
        nsc_pkg::result_t r;
        nib = hex_nibble(c);
        if (pos_count >= nsc_pkg::POS_HDR_LO && pos_count <= nsc_pkg::POS_HDR_HI)
        begin
            hdr[pos_count - 3'd1] = c;
        end
        if (pos_count < nsc_pkg::POS_SAT)
        begin
            pos_count = pos_count + 3'd1;
        end
        if (!star_hit)
        begin
            if (c == nsc_pkg::CH_STAR)
            begin
                star_hit = 1'b1;
            end
            else if (c != nsc_pkg::CH_DOLLAR && c != nsc_pkg::CH_BANG)
            begin
                run_xor = run_xor ^ c;
            end
        end
        else if (!digits_done && digit_cnt < nsc_pkg::HEX_MAX)
        begin
            if (nib < 0)
            begin
                digits_done = 1'b1;
            end
            else
            begin
                digit_val = {digit_val[3:0], 4'(nib)};
                digit_cnt = digit_cnt + 2'd1;
            end
        end
        if (last)
        begin
            r.stype   = classify_header(hdr);
            r.present = (digit_cnt != 2'd0);
            r.rsum    = r.present ? digit_val : 8'd0;
            r.csum    = run_xor;
            r.ok      = r.present && (r.rsum == run_xor);
            sentence_results.push_back(r);
            pos_count   = 3'd0;
            hdr         = '0;
            run_xor     = 8'd0;
            star_hit    = 1'b0;
            digit_cnt   = 2'd0;
            digits_done = 1'b0;
            digit_val   = 8'd0;
        end
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: mismatch on %s: got 0x%0h expected 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        nsc_pkg::result_t want;
        if (sentence_results.size() == 0)
        begin
            report_mismatch("result with none pending", sentence_type, 0);
        end
        else
        begin
            want = sentence_results.pop_front();
            if (sentence_type !== want.stype)
                report_mismatch("sentence_type", sentence_type, want.stype);
            if (checksum_ok !== want.ok)
                report_mismatch("checksum_ok", checksum_ok, want.ok);
            if (computed_sum !== want.csum)
                report_mismatch("computed_sum", computed_sum, want.csum);
            if (received_sum !== want.rsum)
                report_mismatch("received_sum", received_sum, want.rsum);
            if (sum_present !== want.present)
                report_mismatch("sum_present", sum_present, want.present);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                fold_byte(data_byte, end_of_sentence);
            end
            if (!in_valid || !in_stall)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = byte_queue.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= next_byte.b;
                    end_of_sentence <= next_byte.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic push_chars(ref logic [7:0] chars[$]);
        foreach (chars[i])
        begin
            byte_queue.push_back('{chars[i], 1'(i == chars.size() - 1)});
        end
        pushed_count += chars.size();
    endtask

    task automatic push_text(input string s);
        logic [7:0] chars[$];
        int         i;
        for (i = 0; i < s.len(); i++)
        begin
            chars.push_back(s[i]);
        end
        push_chars(chars);
    endtask

    task automatic push_single(input logic [7:0] b);
        logic [7:0] chars[$];
        chars.push_back(b);
        push_chars(chars);
    endtask

    task automatic add_sentence();
        logic [7:0] chars[$];
        logic [7:0] sum;
        logic [7:0] want;
        logic [7:0] c;
        int         kind;
        int         tail;
        int         n;
        bit         lower;
        if ($urandom_range(99) < 15)
        begin
            n = $urandom_range(1, 20);
            repeat (n) chars.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(0, 9);
            if (n < 5)
                chars.push_back(nsc_pkg::CH_DOLLAR);
            else if (n < 9)
                chars.push_back(nsc_pkg::CH_BANG);
            else
                chars.push_back(8'($urandom_range(65, 90)));
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                chars.push_back("P");
                chars.push_back("F");
                chars.push_back("L");
                chars.push_back("A");
                chars.push_back(pfla_last[kind]);
            end
            else if (kind < 8)
            begin
                chars.push_back(8'($urandom_range(65, 90)));
                chars.push_back(8'($urandom_range(65, 90)));
                chars.push_back(tri_tags[kind - 5][23:16]);
                chars.push_back(tri_tags[kind - 5][15:8]);
                chars.push_back(tri_tags[kind - 5][7:0]);
            end
            else
            begin
                n = (kind == 8) ? 5 : $urandom_range(0, 4);
                repeat (n) chars.push_back(8'($urandom_range(65, 90)));
            end
            chars.push_back(",");
            n = $urandom_range(0, 12);
            repeat (n)
            begin
                c = 8'($urandom_range(32, 126));
                chars.push_back(c == nsc_pkg::CH_STAR ? 8'(",") : c);
            end
            sum = 8'd0;
            foreach (chars[i])
            begin
                if (chars[i] != nsc_pkg::CH_DOLLAR && chars[i] != nsc_pkg::CH_BANG)
                    sum = sum ^ chars[i];
            end
            lower = 1'($urandom_range(1));
            tail = $urandom_range(0, 19);
            want = sum;
            if (tail == 12 || tail == 13)
                want = sum ^ 8'($urandom_range(1, 255));
            if (tail != 15)
                chars.push_back(nsc_pkg::CH_STAR);
            if (tail <= 13 || tail == 17)
            begin
                chars.push_back(hex_char(want[7:4], lower));
                chars.push_back(hex_char(want[3:0], lower));
            end
            if (tail <= 11 && $urandom_range(1) == 1)
            begin
                chars.push_back(8'h0D);
                chars.push_back(8'h0A);
            end
            if (tail == 14)
                chars.push_back(hex_char($urandom_range(1) ? sum[3:0] : 4'($urandom), lower));
            if (tail == 16)
            begin
                n = $urandom_range(0, 3);
                chars.push_back(n == 0 ? 8'(" ") : n == 1 ? 8'("-") : n == 2 ? 8'("+")
                                : 8'($urandom_range(0, 255)));
                chars.push_back(hex_char(sum[7:4], lower));
                chars.push_back(hex_char(sum[3:0], lower));
            end
            if (tail == 17)
            begin
                chars.push_back(hex_char(4'($urandom), lower));
                chars.push_back(nsc_pkg::CH_STAR);
            end
            if (tail == 19)
            begin
                chars.push_back(hex_char(sum[7:4], lower));
                chars.push_back(nsc_pkg::CH_STAR);
                chars.push_back(hex_char(sum[3:0], lower));
            end
        end
        push_chars(chars);
    endtask

    task automatic drain();
        while (byte_queue.size() != 0 || in_valid || sentence_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int p;
        int start_count;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero and all-ones bytes, one digit, extra digits, blank, second star, no star
        push_single(8'h00);
        push_single(8'hFF);
        push_text("$A*5");
        push_text("*ff7");
        push_text("!B* 1");
        push_text("$C**");
        push_text("$PFLAU");
        drain();

        for (p = 0; p < 5; p++)
        begin
            send_idle_pct = phase_send[p];
            stall_pct = phase_stall[p];
            start_count = pushed_count;
            while (pushed_count - start_count < 400)
            begin
                add_sentence();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && sentence_results.size() == 0)
        begin
            $display("** nmea_sentence_classify_check: PASSED **");
        end
        else
        begin
            $display("** nmea_sentence_classify_check: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("** nmea_sentence_classify_check: FAILED **");
        $finish;
    end

endmodule
